// ===== rtl/lpp_pkg.sv =====
// Constants, widths, register codes and the pipeline stage record of the lidar point projector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lpp_pkg;

  localparam int COORD_BITS  = 18;
  localparam int PIXEL_BITS  = 12;
  localparam int COEF_W      = 16;
  localparam int FOCAL_W     = 16;
  localparam int THR_W       = 17;
  localparam int INT_W       = 8;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int TRANS_SHIFT = 14;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd7;

  localparam int PROD_W = COEF_W + COORD_BITS;
  localparam int CAM_W  = ((PROD_W > COEF_W + TRANS_SHIFT) ? PROD_W : COEF_W + TRANS_SHIFT) + 2;
  localparam int NUM_W  = FOCAL_W + CAM_W;
  // quotient bits kept; anything larger is off any image
  localparam int QB     = PIXEL_BITS + 5;
  localparam int SQ_W   = 2 * COORD_BITS - 1;
  localparam int S_W    = 2 * COORD_BITS;
  localparam int SS_W   = S_W + 16;
  localparam int R_W    = (SS_W + 1) / 2;
  localparam int NSTEP  = R_W + INT_W;
  localparam int TT_W   = (S_W > 2 * THR_W) ? S_W : 2 * THR_W;
  localparam int U_W    = ((QB > FOCAL_W) ? QB : FOCAL_W) + 2;

  localparam logic [15:0]      INT_SCALE = 16'd65025;
  localparam logic [INT_W-1:0] INT_MAX   = 8'd255;

  localparam logic [CFG_DATA_W-1:0] ROT_ROW0_RST  = 48'h0000_4000_0000;
  localparam logic [CFG_DATA_W-1:0] ROT_ROW1_RST  = 48'h0000_0000_4000;
  localparam logic [THR_W-1:0]      THRESHOLD_RST = 17'd100000;

  typedef struct packed {
    logic              neg_u;
    logic              neg_v;
    logic              ovf_u;
    logic              ovf_v;
    logic              pos;
    logic              sat;
    logic [NUM_W-1:0]  num_u;
    logic [NUM_W-1:0]  num_v;
    logic [CAM_W-1:0]  d;
    logic [CAM_W-1:0]  rem_u;
    logic [CAM_W-1:0]  rem_v;
    logic [QB-1:0]     q_u;
    logic [QB-1:0]     q_v;
    logic [SS_W-1:0]   srem;
    logic [R_W-1:0]    root;
    logic [THR_W-1:0]  krem;
    logic [INT_W-1:0]  k;
  } stage_t;

  typedef struct packed {
    logic [CAM_W-1:0] rem;
    logic             q;
  } dstep_t;

  // one restoring division step: shift in a numerator bit, subtract if it fits
  function automatic dstep_t div_step(input logic [CAM_W-1:0] rem, input logic nb,
                                      input logic [CAM_W-1:0] d);
    logic [CAM_W:0] t;
    dstep_t r;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      r.rem = CAM_W'(t - {1'b0, d});
      r.q   = 1'b1;
    end else begin
      r.rem = t[CAM_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/lpp_ifs.sv =====
// Handshake channels of the lidar point projector: point items, result items, register writes.
// Depends on lpp_pkg for the field widths.
interface lpp_point_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [lpp_pkg::COORD_BITS-1:0] point_x;
  logic signed [lpp_pkg::COORD_BITS-1:0] point_y;
  logic signed [lpp_pkg::COORD_BITS-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_result_if;
  logic                           valid;
  logic                           ready;
  logic                           inside_res;
  logic [lpp_pkg::PIXEL_BITS-1:0] pixel_col;
  logic [lpp_pkg::PIXEL_BITS-1:0] pixel_row;
  logic [lpp_pkg::INT_W-1:0]      intensity;
  modport source(output valid, inside_res, pixel_col, pixel_row, intensity, input ready);
  modport sink(input valid, inside_res, pixel_col, pixel_row, intensity, output ready);
endinterface

interface lpp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lpp_pkg::CFG_IDX_W-1:0]  index;
  logic [lpp_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/lidar_point_projector.sv =====
// Lidar point projector top level: configuration registers and the full projection pipeline.
// Depends on lpp_pkg and the channel interfaces in lpp_ifs.sv.
//
// Takes one lidar point (x, y, z in signed millimetres) per cycle and returns one result item
// per point, in order. The point is rotated (Q2.14) and translated into the camera frame,
// divided by camera depth and scaled by the pinhole intrinsics; the result tells whether the
// pixel falls inside the configured image, gives its truncated column and row, and an
// intensity of range * 255 / dist_threshold saturated at 255. Points at or behind the camera
// and points off the image give inside_res = 0 with all other fields zero. Throughput is one
// item per clock. The latency is set by the range path: a 26-step square root (one result bit
// per stage) followed by an 8-step division by the threshold; the two depth divisions (17
// quotient bits, one per stage) run alongside it. All stages advance together on a single
// enable: when the output register holds an unread result, the whole pipeline and the point
// input stall, and nothing is lost or repeated. Register writes are taken in any cycle (ready
// is always high) and must only occur while no item is in flight.
module lidar_point_projector (
  input  logic        clk,
  input  logic        rst,
  lpp_cfg_if.sink     cfg,
  lpp_point_if.sink   pt,
  lpp_result_if.source res
);

  localparam int CB    = lpp_pkg::COORD_BITS;
  localparam int PB    = lpp_pkg::PIXEL_BITS;
  localparam int CW    = lpp_pkg::COEF_W;
  localparam int CAM_W = lpp_pkg::CAM_W;
  localparam int NUM_W = lpp_pkg::NUM_W;
  localparam int QB    = lpp_pkg::QB;
  localparam int SS_W  = lpp_pkg::SS_W;
  localparam int S_W   = lpp_pkg::S_W;
  localparam int R_W   = lpp_pkg::R_W;
  localparam int THR_W = lpp_pkg::THR_W;
  localparam int INT_W = lpp_pkg::INT_W;
  localparam int NSTEP = lpp_pkg::NSTEP;
  localparam int U_W   = lpp_pkg::U_W;
  localparam int TT_W  = lpp_pkg::TT_W;

  // ---------------------------------------------------------------- configuration registers
  logic [lpp_pkg::CFG_DATA_W-1:0] rot_row0, rot_row1, rot_row2, translation;
  logic [31:0]                    focal_lengths, principal_point;
  logic [2*PB-1:0]                image_size;
  logic [THR_W-1:0]               dist_threshold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0        <= lpp_pkg::ROT_ROW0_RST;
      rot_row1        <= lpp_pkg::ROT_ROW1_RST;
      rot_row2        <= '0;
      translation     <= '0;
      focal_lengths   <= '0;
      principal_point <= '0;
      image_size      <= '0;
      dist_threshold  <= lpp_pkg::THRESHOLD_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lpp_pkg::REG_ROT_ROW0:    rot_row0        <= cfg.data;
        lpp_pkg::REG_ROT_ROW1:    rot_row1        <= cfg.data;
        lpp_pkg::REG_ROT_ROW2:    rot_row2        <= cfg.data;
        lpp_pkg::REG_TRANSLATION: translation     <= cfg.data;
        lpp_pkg::REG_FOCAL:       focal_lengths   <= cfg.data[31:0];
        lpp_pkg::REG_PRINCIPAL:   principal_point <= cfg.data[31:0];
        lpp_pkg::REG_IMAGE_SIZE:  image_size      <= cfg.data[2*PB-1:0];
        lpp_pkg::REG_THRESHOLD:   dist_threshold  <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack coefficients: column 0 sits in the high 16 bits of each row
  logic [lpp_pkg::CFG_DATA_W-1:0] rows [3];
  logic signed [CW-1:0]           rc [3][3];
  logic signed [CW-1:0]           tc [3];
  logic [15:0]                    fx, fy, cx, cy;
  logic [PB-1:0]                  img_w, img_h;

  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tc[i] = translation[47-16*i -: 16];
      for (int j = 0; j < 3; j++) begin
        rc[i][j] = rows[i][47-16*j -: 16];
      end
    end
  end

  assign fx    = focal_lengths[31:16];
  assign fy    = focal_lengths[15:0];
  assign cx    = principal_point[31:16];
  assign cy    = principal_point[15:0];
  assign img_w = image_size[2*PB-1:PB];
  assign img_h = image_size[PB-1:0];

  // ---------------------------------------------------------------- pipeline enable
  // Advance every stage unless the output register holds an item nobody has taken.
  logic out_valid;
  logic en;

  assign en       = !out_valid || res.ready;
  assign pt.ready = en;

  // ---------------------------------------------------------------- stage 1: products
  logic signed [CB-1:0]              pin [3];
  logic signed [lpp_pkg::PROD_W-1:0] prod_c [3][3];
  logic signed [S_W-1:0]             psq_c [3];
  logic                              v1;
  logic signed [lpp_pkg::PROD_W-1:0] prod [3][3];
  logic [lpp_pkg::SQ_W-1:0]          sq [3];

  assign pin[0] = pt.point_x;
  assign pin[1] = pt.point_y;
  assign pin[2] = pt.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psq_c[i] = pin[i] * pin[i];
      for (int j = 0; j < 3; j++) begin
        prod_c[i][j] = rc[i][j] * pin[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= psq_c[i][lpp_pkg::SQ_W-1:0];
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= prod_c[i][j];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 2: camera frame
  // cam = t * 2^14 + R * p, exact in Q.14 millimetres; s = squared range
  logic signed [CAM_W-1:0] cam_c [3];
  logic [S_W-1:0]          s_c;
  logic                    v2;
  logic signed [CAM_W-1:0] cam [3];
  logic [S_W-1:0]          s2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_c[i] = (CAM_W'(tc[i]) <<< lpp_pkg::TRANS_SHIFT) + CAM_W'(prod[i][0])
               + CAM_W'(prod[i][1]) + CAM_W'(prod[i][2]);
    end
    s_c = S_W'(sq[0]) + S_W'(sq[1]) + S_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cam <= cam_c;
      s2  <= s_c;
    end
  end

  // ---------------------------------------------------------------- stage 3: scale numerators
  logic [CAM_W-1:0] mag_u, mag_v;
  logic             v3, neg_u3, neg_v3, pos3, sat3;
  logic [NUM_W-1:0] num_u3, num_v3;
  logic [CAM_W-1:0] d3;
  logic [SS_W-1:0]  ss3;

  assign mag_u = cam[0][CAM_W-1] ? CAM_W'(-cam[0]) : cam[0];
  assign mag_v = cam[1][CAM_W-1] ? CAM_W'(-cam[1]) : cam[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_u3 <= cam[0][CAM_W-1];
      neg_v3 <= cam[1][CAM_W-1];
      pos3   <= !cam[2][CAM_W-1] && (cam[2] != '0);
      d3     <= cam[2];
      num_u3 <= NUM_W'(fx) * NUM_W'(mag_u);
      num_v3 <= NUM_W'(fy) * NUM_W'(mag_v);
      ss3    <= SS_W'(lpp_pkg::INT_SCALE) * SS_W'(s2);
      // range at or beyond the threshold maps straight to full intensity
      sat3   <= (TT_W'(dist_threshold) * TT_W'(dist_threshold)) <= TT_W'(s2);
    end
  end

  // ---------------------------------------------------------------- stage 4: division setup
  lpp_pkg::stage_t pipe [0:NSTEP];
  logic            vld  [0:NSTEP];
  lpp_pkg::stage_t init_c;

  always_comb begin
    init_c       = '0;
    init_c.neg_u = neg_u3;
    init_c.neg_v = neg_v3;
    init_c.pos   = pos3;
    init_c.sat   = sat3;
    init_c.num_u = num_u3;
    init_c.num_v = num_v3;
    init_c.d     = d3;
    // a quotient of 2^QB or more is off any image: flag it; the long division still runs, unused
    init_c.ovf_u = (num_u3 >> QB) >= NUM_W'(d3);
    init_c.ovf_v = (num_v3 >> QB) >= NUM_W'(d3);
    init_c.rem_u = CAM_W'(num_u3 >> QB);
    init_c.rem_v = CAM_W'(num_v3 >> QB);
    init_c.srem  = ss3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= init_c;
    end
  end

  // ---------------------------------------------------------------- iterative stages
  // Each stage produces one quotient bit of both depth divisions (first QB stages), one bit
  // of isqrt(65025 * s) (first R_W stages), then one bit of that root over the threshold.
  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam logic DO_DIV = (j < QB);
    lpp_pkg::dstep_t du, dv;
    logic [SS_W-1:0]  srem_n;
    logic [R_W-1:0]   root_n;
    logic [THR_W-1:0] krem_n;
    logic [INT_W-1:0] k_n;
    lpp_pkg::stage_t  nxt;

    if (j < QB) begin : g_div
      localparam int QI = QB - 1 - j;
      assign du = lpp_pkg::div_step(pipe[j].rem_u, pipe[j].num_u[QI], pipe[j].d);
      assign dv = lpp_pkg::div_step(pipe[j].rem_v, pipe[j].num_v[QI], pipe[j].d);
    end else begin : g_div_hold
      assign du = '{rem: pipe[j].rem_u, q: 1'b0};
      assign dv = '{rem: pipe[j].rem_v, q: 1'b0};
    end

    if (j < R_W) begin : g_sqrt
      localparam int SB = R_W - 1 - j;
      logic [SS_W+1:0] trial;
      logic [SS_W+1:0] srem_x;
      // (root + 2^SB)^2 - root^2 = root * 2^(SB+1) + 2^(2*SB)
      assign trial  = ((SS_W+2)'(pipe[j].root) << (SB + 1)) | ((SS_W+2)'(1) << (2 * SB));
      assign srem_x = (SS_W+2)'(pipe[j].srem);
      always_comb begin
        if (srem_x >= trial) begin
          srem_n = SS_W'(srem_x - trial);
          root_n = pipe[j].root | (R_W'(1) << SB);
        end else begin
          srem_n = pipe[j].srem;
          root_n = pipe[j].root;
        end
      end
      assign krem_n = pipe[j].krem;
      assign k_n    = pipe[j].k;
    end else begin : g_kdiv
      localparam int KI = INT_W - 1 - (j - R_W);
      logic [THR_W-1:0] rin;
      logic [THR_W:0]   kt;
      // root >> 8 is below the threshold whenever the result is not saturated
      if (j == R_W) begin : g_first
        assign rin = THR_W'(pipe[j].root >> INT_W);
      end else begin : g_next
        assign rin = pipe[j].krem;
      end
      assign kt = {rin, pipe[j].root[KI]};
      always_comb begin
        if (kt >= {1'b0, dist_threshold}) begin
          krem_n = THR_W'(kt - {1'b0, dist_threshold});
          k_n    = {pipe[j].k[INT_W-2:0], 1'b1};
        end else begin
          krem_n = kt[THR_W-1:0];
          k_n    = {pipe[j].k[INT_W-2:0], 1'b0};
        end
      end
      assign srem_n = pipe[j].srem;
      assign root_n = pipe[j].root;
    end

    always_comb begin
      nxt       = pipe[j];
      nxt.rem_u = du.rem;
      nxt.rem_v = dv.rem;
      if (DO_DIV) begin
        nxt.q_u = {pipe[j].q_u[QB-2:0], du.q};
        nxt.q_v = {pipe[j].q_v[QB-2:0], dv.q};
      end
      nxt.srem = srem_n;
      nxt.root = root_n;
      nxt.krem = krem_n;
      nxt.k    = k_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[j+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------- final: pixel and bounds
  // floor of a negative quotient is -q - 1 when the division left a remainder
  lpp_pkg::stage_t fin;
  logic [U_W-1:0]  qs_u, qs_v, u4, v4;
  logic            in_c;

  assign fin = pipe[NSTEP];

  always_comb begin
    qs_u = fin.neg_u ? U_W'(-U_W'(fin.q_u) - U_W'(fin.rem_u != '0)) : U_W'(fin.q_u);
    qs_v = fin.neg_v ? U_W'(-U_W'(fin.q_v) - U_W'(fin.rem_v != '0)) : U_W'(fin.q_v);
    u4   = qs_u + U_W'(cx);
    v4   = qs_v + U_W'(cy);
    in_c = fin.pos && !fin.ovf_u && !fin.ovf_v && !u4[U_W-1] && !v4[U_W-1]
        && (u4[U_W-2:4] < (U_W-5)'(img_w)) && (v4[U_W-2:4] < (U_W-5)'(img_h));
  end

  logic             out_inside;
  logic [PB-1:0]    out_col, out_row;
  logic [INT_W-1:0] out_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NSTEP];
    end
  end

  // drop everything but the flag when the point misses the image
  always_ff @(posedge clk) begin
    if (en) begin
      out_inside <= in_c;
      out_col    <= in_c ? u4[PB+3:4] : '0;
      out_row    <= in_c ? v4[PB+3:4] : '0;
      out_int    <= in_c ? (fin.sat ? lpp_pkg::INT_MAX : fin.k) : '0;
    end
  end

  assign res.valid      = out_valid;
  assign res.inside_res = out_inside;
  assign res.pixel_col  = out_col;
  assign res.pixel_row  = out_row;
  assign res.intensity  = out_int;

  // ---------------------------------------------------------------- assertions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !pt.ready)
    else $error("point input open while a result is held");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (pt.valid && pt.ready) |=> v1)
    else $error("accepted point did not enter the pipeline");

  a_stall_holds_tail: assert property (@(posedge clk) disable iff (rst)
    (!pt.ready) |=> (vld[NSTEP] == $past(vld[NSTEP])))
    else $error("pipeline tail moved during a stall");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.inside_res) |->
      (res.pixel_col == '0 && res.pixel_row == '0 && res.intensity == '0))
    else $error("result outside the image carries nonzero fields");

endmodule

// ===== tb/lidar_point_projector_tb.sv =====
// Self-checking testbench of lidar_point_projector: directed and random points under several
// register settings, predicted in-bench and compared item by item. Uses lpp_pkg, lpp_ifs.sv.
module lidar_point_projector_tb;

  localparam int  CB = lpp_pkg::COORD_BITS;
  localparam int  PB = lpp_pkg::PIXEL_BITS;
  localparam int  IW = lpp_pkg::INT_W;
  localparam int  DW = lpp_pkg::CFG_DATA_W;
  localparam int  TW = lpp_pkg::THR_W;
  localparam int  XW = lpp_pkg::CFG_IDX_W;

  localparam int  CYCLE_LIMIT = 400000;
  localparam int  DRAIN_GAP   = 50;   // a little more than the pipeline latency
  localparam longint QSAT_MAG = 64'd1 << 40;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } point_t;

  typedef struct packed {
    logic          in_img;
    logic [PB-1:0] col;
    logic [PB-1:0] row;
    logic [IW-1:0] inten;
  } pixel_t;

  logic clk;
  logic rst;

  lpp_cfg_if    cfg();
  lpp_point_if  pt();
  lpp_result_if res();

  lidar_point_projector uut (.clk(clk), .rst(rst), .cfg(cfg.sink), .pt(pt.sink),
                             .res(res.source));

  // Shadow copy of the block's registers, updated at each accepted register write.
  logic [DW-1:0]   sh_rot [3];
  logic [DW-1:0]   sh_trans;
  logic [31:0]     sh_focal;
  logic [31:0]     sh_princ;
  logic [2*PB-1:0] sh_img;
  logic [TW-1:0]   sh_thr;

  point_t point_q[$];
  pixel_t pixel_q[$];
  int     send_idle_pct;
  int     recv_idle_pct;
  int     errors;
  int     n_results;
  int     n_inside;
  int     cycles;

  // floor(f * num / den) with the quotient magnitude clamped at 2^40
  function automatic longint floor_scaled(longint f, longint num, longint den);
    longint a, prod, q, r;
    a    = (num < 0) ? -num : num;
    prod = f * a;
    q    = prod / den;
    r    = prod % den;
    if (q > QSAT_MAG) q = QSAT_MAG;
    return (num < 0) ? (-q - ((r != 0) ? 1 : 0)) : q;
  endfunction

  // floor(range * 255 / threshold), saturated; exact by bitwise search
  function automatic logic [IW-1:0] range_intensity(longint x, longint y, longint z);
    longint s, t, k, c;
    s = x * x + y * y + z * z;
    t = longint'(sh_thr);
    k = 0;
    if (s >= t * t) return lpp_pkg::INT_MAX;
    for (int b = 128; b != 0; b = b >> 1) begin
      c = k | b;
      if (c <= 254 && (c * t) * (c * t) <= 65025 * s) k = c;
    end
    return IW'(k);
  endfunction

  function automatic pixel_t project_point(point_t p);
    longint pv [3];
    longint cam [3];
    longint acc, u4, v4, w, h;
    pixel_t o;
    pv[0] = longint'(p.x);
    pv[1] = longint'(p.y);
    pv[2] = longint'(p.z);
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(sh_trans[47-16*i -: 16])) * 16384;
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(sh_rot[i][47-16*j -: 16])) * pv[j];
      cam[i] = acc;
    end
    o = '0;
    // at or behind the camera: outside, all fields zero
    if (cam[2] <= 0) return o;
    u4 = floor_scaled(longint'(sh_focal[31:16]), cam[0], cam[2]) + longint'(sh_princ[31:16]);
    v4 = floor_scaled(longint'(sh_focal[15:0]), cam[1], cam[2]) + longint'(sh_princ[15:0]);
    w  = longint'(sh_img[2*PB-1:PB]);
    h  = longint'(sh_img[PB-1:0]);
    if (u4 < 0 || v4 < 0) return o;
    if ((u4 >> 4) >= w || (v4 >> 4) >= h) return o;
    o.in_img = 1'b1;
    o.col    = PB'(u4 >> 4);
    o.row    = PB'(v4 >> 4);
    o.inten  = range_intensity(pv[0], pv[1], pv[2]);
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Point driver: hold the item until accepted, then advance from the queue or idle.
  always @(posedge clk) begin
    if (rst) begin
      pt.valid   <= 1'b0;
      pt.point_x <= '0;
      pt.point_y <= '0;
      pt.point_z <= '0;
    end else if (!pt.valid || pt.ready) begin
      if (pt.valid)
        pixel_q.insert(pixel_q.size(),
                       project_point('{pt.point_x, pt.point_y, pt.point_z}));
      if (point_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        point_t nx;
        nx = point_q.pop_front();
        pt.valid   <= 1'b1;
        pt.point_x <= nx.x;
        pt.point_y <= nx.y;
        pt.point_z <= nx.z;
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted item with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        pixel_t got, want;
        got = '{res.inside_res, res.pixel_col, res.pixel_row, res.intensity};
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result in_img=%0d col=%0d row=%0d int=%0d", $time,
                   got.in_img, got.col, got.row, got.inten);
        end else begin
          want = pixel_q.pop_front();
          n_results++;
          if (want.in_img) n_inside++;
          if (got !== want) begin
            errors++;
            // fields in order: in_img/col/row/intensity
            $display("%0t: mismatch expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                     $time, want.in_img, want.col, want.row, want.inten,
                     got.in_img, got.col, got.row, got.inten);
          end
        end
      end
      res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_point(point_t p);
    point_q.insert(point_q.size(), p);
  endtask

  // Write one register; leave valid high so back-to-back writes need no second assignment.
  task automatic write_reg(logic [XW-1:0] idx, logic [DW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      lpp_pkg::REG_ROT_ROW0:    sh_rot[0] = val;
      lpp_pkg::REG_ROT_ROW1:    sh_rot[1] = val;
      lpp_pkg::REG_ROT_ROW2:    sh_rot[2] = val;
      lpp_pkg::REG_TRANSLATION: sh_trans  = val;
      lpp_pkg::REG_FOCAL:       sh_focal  = val[31:0];
      lpp_pkg::REG_PRINCIPAL:   sh_princ  = val[31:0];
      lpp_pkg::REG_IMAGE_SIZE:  sh_img    = val[2*PB-1:0];
      default:                  sh_thr    = val[TW-1:0];
    endcase
  endtask

  // Wait until every item has come back, then let the pipeline go quiet.
  task automatic drain();
    while (point_q.size() != 0 || pt.valid || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  function automatic logic [15:0] near_coef(int base);
    return 16'(base + $urandom_range(0, 3000) - 1500);
  endfunction

  // Near-identity camera with random intrinsics sized to the image; leaves valid high.
  task automatic cfg_camera(logic [TW-1:0] thr);
    int w, h;
    w = $urandom_range(64, 4095);
    h = $urandom_range(64, 4095);
    write_reg(lpp_pkg::REG_ROT_ROW0, {near_coef(16384), near_coef(0), near_coef(0)});
    write_reg(lpp_pkg::REG_ROT_ROW1, {near_coef(0), near_coef(16384), near_coef(0)});
    write_reg(lpp_pkg::REG_ROT_ROW2, {near_coef(0), near_coef(0), near_coef(16384)});
    write_reg(lpp_pkg::REG_TRANSLATION, {16'($urandom_range(0, 4000) - 2000),
                                         16'($urandom_range(0, 4000) - 2000),
                                         16'($urandom_range(0, 2000))});
    write_reg(lpp_pkg::REG_FOCAL, DW'({16'($urandom_range(2000, 65535)),
                                       16'($urandom_range(2000, 65535))}));
    write_reg(lpp_pkg::REG_PRINCIPAL, DW'({16'(w * 8), 16'(h * 8)}));
    write_reg(lpp_pkg::REG_IMAGE_SIZE, DW'({12'(w), 12'(h)}));
    write_reg(lpp_pkg::REG_THRESHOLD, DW'(thr));
  endtask

  function automatic point_t rand_point();
    point_t p;
    int z;
    if ($urandom_range(0, 9) < 7) begin
      // in front of the camera, within the field of view most of the time
      z = $urandom_range(200, 131071);
      p.z = CB'(z);
      p.x = CB'(int'($urandom_range(0, 2 * z)) - z);
      p.y = CB'(int'($urandom_range(0, 2 * z)) - z);
    end else begin
      p = $bits(point_t)'({$urandom, $urandom});
    end
    return p;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) add_point(rand_point());
    drain();
  endtask

  localparam logic signed [CB-1:0] PMAX = CB'((1 <<< (CB - 1)) - 1);
  localparam logic signed [CB-1:0] PMIN = CB'(-(1 <<< (CB - 1)));

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 66;
    sh_rot[0] = lpp_pkg::ROT_ROW0_RST;
    sh_rot[1] = lpp_pkg::ROT_ROW1_RST;
    sh_rot[2] = '0;
    sh_trans  = '0;
    sh_focal  = '0;
    sh_princ  = '0;
    sh_img    = '0;
    sh_thr    = lpp_pkg::THRESHOLD_RST;
    rst <= 1'b1;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero image, so nothing may land inside.
    add_point('{18'sd100, 18'sd200, 18'sd300});
    add_point('{PMAX, PMAX, PMAX});
    add_point('{PMIN, PMIN, PMIN});
    drain();

    // Directed: plain camera 1280x720, focal 500 px, threshold 100 m.
    write_reg(lpp_pkg::REG_ROT_ROW0, 48'h4000_0000_0000);
    write_reg(lpp_pkg::REG_ROT_ROW1, 48'h0000_4000_0000);
    write_reg(lpp_pkg::REG_ROT_ROW2, 48'h0000_0000_4000);
    write_reg(lpp_pkg::REG_TRANSLATION, '0);
    write_reg(lpp_pkg::REG_FOCAL, DW'({16'd8000, 16'd8000}));
    write_reg(lpp_pkg::REG_PRINCIPAL, DW'({16'd10240, 16'd5760}));
    write_reg(lpp_pkg::REG_IMAGE_SIZE, DW'({12'd1280, 12'd720}));
    write_reg(lpp_pkg::REG_THRESHOLD, DW'(17'd100000));
    cfg.valid <= 1'b0;
    add_point('{18'sd0, 18'sd0, 18'sd0});         // depth zero
    add_point('{18'sd0, 18'sd0, -18'sd1000});     // behind the camera
    add_point('{18'sd0, 18'sd0, 18'sd1});         // just in front, center
    add_point('{18'sd0, 18'sd0, PMAX});
    add_point('{PMAX, 18'sd0, 18'sd1});           // huge quotient, off to the right
    add_point('{PMIN, PMIN, 18'sd1});             // huge negative quotient
    add_point('{18'sd1280, 18'sd720, 18'sd1000}); // right and bottom borders
    add_point('{18'sd1279, 18'sd719, 18'sd1000});
    add_point('{-18'sd1280, -18'sd720, 18'sd1000}); // top-left corner
    add_point('{-18'sd1281, 18'sd0, 18'sd1000});
    add_point('{18'sd0, 18'sd0, 18'sd100000});    // range exactly at threshold
    add_point('{18'sd0, 18'sd0, 18'sd99999});
    add_point('{18'sd10, -18'sd20, 18'sd500});
    add_point('{PMAX, PMAX, PMAX});
    add_point('{PMIN, PMAX, PMAX});
    add_point('{PMIN, PMIN, PMIN});
    drain();

    // Phase 1: sender idles 33%, receiver 66%.
    cfg_camera(17'($urandom_range(1000, 131071)));
    cfg.valid <= 1'b0;
    run_random(240);
    // Extremes: every register all ones.
    write_reg(lpp_pkg::REG_ROT_ROW0, '1);
    write_reg(lpp_pkg::REG_ROT_ROW1, '1);
    write_reg(lpp_pkg::REG_ROT_ROW2, '1);
    write_reg(lpp_pkg::REG_TRANSLATION, '1);
    write_reg(lpp_pkg::REG_FOCAL, '1);
    write_reg(lpp_pkg::REG_PRINCIPAL, '1);
    write_reg(lpp_pkg::REG_IMAGE_SIZE, '1);
    write_reg(lpp_pkg::REG_THRESHOLD, '1);
    cfg.valid <= 1'b0;
    run_random(240);

    // Phase 2: the other way round.
    send_idle_pct = 66;
    recv_idle_pct = 33;
    cfg_camera('0);  // zero threshold saturates the intensity
    cfg.valid <= 1'b0;
    run_random(240);
    cfg_camera(17'd1);
    write_reg(lpp_pkg::REG_IMAGE_SIZE, DW'({12'd0, 12'd4095}));  // zero width: never inside
    cfg.valid <= 1'b0;
    run_random(120);
    write_reg(lpp_pkg::REG_IMAGE_SIZE, DW'({12'd4095, 12'd0}));
    cfg.valid <= 1'b0;
    run_random(120);

    // Phase 3: no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = lpp_pkg::REG_ROT_ROW0; k <= lpp_pkg::REG_THRESHOLD; k++)
      write_reg(XW'(k), DW'({$urandom, $urandom}));
    cfg.valid <= 1'b0;
    run_random(240);
    cfg_camera(17'd131071);
    write_reg(lpp_pkg::REG_FOCAL, DW'({16'hFFFF, 16'hFFFF}));
    write_reg(lpp_pkg::REG_PRINCIPAL, '0);
    cfg.valid <= 1'b0;
    run_random(250);

    $display("Checked %0d result items (%0d inside the image) over reset, directed, extreme",
             n_results, n_inside);
    $display("and random register settings, with stalls on either side and at full rate.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
